// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, suspended while rst is high.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/dasl_pkg.sv -----
`default_nettype none

package dasl_pkg;

  typedef struct packed {
    logic signed [15:0] request_x;
    logic signed [15:0] request_y;
    logic [19:0]        tick_us;
    logic [31:0]        object_id;
    logic [1:0]         lifecycle;
    logic [1:0]         mode_code;
  } req_item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
  } res_item_t;

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [31:0]        object_id;
    logic [1:0]         lifecycle;
    logic [1:0]         mode_code;
  } ctl_t;

  typedef struct packed {
    logic [14:0] rise_ord;
    logic [14:0] decay_ord;
    logic [14:0] rise_ho;
    logic [14:0] decay_ho;
  } step_set_t;

  localparam logic [1:0] LIFE_NONE    = 2'd0;
  localparam logic [1:0] LIFE_CONT    = 2'd1;
  localparam logic [1:0] MODE_MANUAL  = 2'd0;
  localparam logic [1:0] MODE_ACQUIRE = 2'd1;
  localparam logic [1:0] MODE_FOLLOW  = 2'd2;

  localparam logic [1:0] REG_RISE_RATE  = 2'd0;
  localparam logic [1:0] REG_DECAY_RATE = 2'd1;
  localparam logic [1:0] REG_MAX_STEP   = 2'd2;

  localparam logic [21:0] RISE_RATE_RST  = 22'd65536;
  localparam logic [21:0] DECAY_RATE_RST = 22'd131072;
  localparam logic [14:0] MAX_STEP_RST   = 15'd1638;

  localparam logic [19:0] TICK_MIN_US = 20'd100;
  localparam logic [19:0] TICK_MAX_US = 20'd50000;

  // One million is 64 times 15625; the odd part is divided by a scaled reciprocal.
  localparam int          DIV_SHIFT   = 6;
  localparam logic [13:0] DIV_ODD     = 14'd15625;
  localparam logic [31:0] RECIP_M     = 32'd2251799813;
  localparam int          RECIP_SHIFT = 45;

  localparam logic [14:0] HANDOFF_ENV = 15'd2621;
  localparam logic [14:0] HANDOFF_CAP = 15'd2294;

endpackage

`default_nettype wire

// ----- rtl/core/dual_axis_slew_limiter_unit.sv -----
`default_nettype none

// Dual-axis asymmetric slew limiter. Each request transfer yields exactly one
// result transfer carrying the new held output pair, via the input register,
// three step stages and the output register. One request can be taken every
// cycle while the result side does not stall: the step stages work out the
// rise and decay step sizes from the tick time without the held state, and the
// output stage applies the slew, reversal, object-change and handoff rules to
// the held pair, the loop that sets the one-cycle rate. The rise rate, decay
// rate and step cap registers lie at addresses 0, 4 and 8 and may be written
// only while no transfer is in flight.

`include "assert_macros.svh"

module dual_axis_slew_limiter_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire dasl_pkg::req_item_t  req_data,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output dasl_pkg::res_item_t       res_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dasl_pkg::*;

  logic [21:0] rise_rate;
  logic [21:0] decay_rate;
  logic [14:0] max_step;

  logic      v1, v2, v3, v4;
  logic      ld1, ld2, ld3, ld4, ld_out;
  req_item_t s1;
  ctl_t      s2_ctl, s3_ctl, s4_ctl;
  logic [37:0] s2_prod_rise, s2_prod_decay;
  logic [31:0] s3_a_rise, s3_a_decay;
  logic [18:0] s3_q_rise, s3_q_decay;
  step_set_t   s4_steps;

  logic signed [15:0] level_x, level_y;
  logic [31:0]        last_id;
  logic [1:0]         last_mode;
  logic               primed;

  logic [15:0] tick_c;
  ctl_t        ctl_c;
  logic [37:0] prod_rise_c, prod_decay_c;
  logic [63:0] recip_rise_c, recip_decay_c;
  logic [19:0] q_rise_c, q_decay_c;
  step_set_t   steps_c;

  logic               changed, handoff;
  logic signed [15:0] base_x, base_y, rqx, rqy;
  logic signed [15:0] level_x_next, level_y_next;

  function automatic logic [16:0] magn(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] slew_axis(input logic signed [15:0] cur,
                                                   input logic signed [15:0] req,
                                                   input logic [14:0] rstep,
                                                   input logic [14:0] dstep);
    logic               rev, dec;
    logic signed [15:0] tgt;
    logic signed [17:0] stp, diff, d;
    rev  = (cur < 0 && req > 0) || (cur > 0 && req < 0);
    tgt  = rev ? 16'sd0 : req;
    dec  = rev || (magn(tgt) < magn(cur));
    stp  = $signed({3'b000, dec ? dstep : rstep});
    diff = {{2{tgt[15]}}, tgt} - {{2{cur[15]}}, cur};
    if (diff > stp) begin
      d = stp;
    end else if (diff < -stp) begin
      d = -stp;
    end else begin
      d = diff;
    end
    return sat16({{2{cur[15]}}, cur} + d);
  endfunction

  function automatic logic signed [15:0] handoff_slew(input logic signed [15:0] cur,
                                                      input logic signed [15:0] req,
                                                      input logic [14:0] rstep,
                                                      input logic [14:0] dstep);
    logic signed [17:0] lo, hi, c;
    lo = {{2{req[15]}}, req} - $signed({3'b000, HANDOFF_ENV});
    hi = {{2{req[15]}}, req} + $signed({3'b000, HANDOFF_ENV});
    c  = {{2{cur[15]}}, cur};
    if ({1'b0, magn(cur)} > {1'b0, magn(req)} + {3'b000, HANDOFF_ENV}) begin
      if (c < lo) begin
        c = lo;
      end else if (c > hi) begin
        c = hi;
      end
      return sat16(c);
    end
    return slew_axis(cur, req, rstep, dstep);
  endfunction

  function automatic logic signed [15:0] no_rise(input logic signed [15:0] req,
                                                 input logic signed [15:0] cur);
    logic same;
    same = !((req < 0 && cur > 0) || (req > 0 && cur < 0));
    return (same && magn(req) > magn(cur)) ? cur : req;
  endfunction

  function automatic logic [19:0] fix_quot(input logic [31:0] a, input logic [18:0] q0);
    logic [32:0] back, rem;
    back = 33'(q0) * 33'(DIV_ODD);
    rem  = {1'b0, a} - back;
    return (rem >= 33'(DIV_ODD)) ? 20'(q0) + 20'd1 : 20'(q0);
  endfunction

  function automatic logic [14:0] cap_step(input logic [19:0] q, input logic [14:0] c);
    return (q > 20'(c)) ? c : q[14:0];
  endfunction

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_rate  <= RISE_RATE_RST;
      decay_rate <= DECAY_RATE_RST;
      max_step   <= MAX_STEP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_RISE_RATE:  rise_rate  <= pwdata[21:0];
        REG_DECAY_RATE: decay_rate <= pwdata[21:0];
        REG_MAX_STEP:   max_step   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RISE_RATE:  prdata = {10'd0, rise_rate};
      REG_DECAY_RATE: prdata = {10'd0, decay_rate};
      REG_MAX_STEP:   prdata = {17'd0, max_step};
      default:        prdata = '0;
    endcase
  end

  // Stage loads: a stage takes new contents when it is empty or moves on.
  assign ld_out    = !res_valid || !res_stall;
  assign ld4       = !v4 || ld_out;
  assign ld3       = !v3 || ld4;
  assign ld2       = !v2 || ld3;
  assign ld1       = !v1 || ld2;
  assign req_stall = !ld1;

  always_comb begin
    if (s1.tick_us < TICK_MIN_US) begin
      tick_c = TICK_MIN_US[15:0];
    end else if (s1.tick_us > TICK_MAX_US) begin
      tick_c = TICK_MAX_US[15:0];
    end else begin
      tick_c = s1.tick_us[15:0];
    end
    ctl_c.object_id = s1.object_id;
    ctl_c.lifecycle = s1.lifecycle;
    ctl_c.mode_code = s1.mode_code;
    if (s1.lifecycle == LIFE_NONE || s1.mode_code == MODE_MANUAL) begin
      ctl_c.rx = '0;
      ctl_c.ry = '0;
    end else begin
      ctl_c.rx = s1.request_x;
      ctl_c.ry = s1.request_y;
    end
  end

  assign prod_rise_c   = 38'(rise_rate) * 38'(tick_c);
  assign prod_decay_c  = 38'(decay_rate) * 38'(tick_c);
  assign recip_rise_c  = 64'(s2_prod_rise[37:DIV_SHIFT]) * 64'(RECIP_M);
  assign recip_decay_c = 64'(s2_prod_decay[37:DIV_SHIFT]) * 64'(RECIP_M);
  assign q_rise_c      = fix_quot(s3_a_rise, s3_q_rise);
  assign q_decay_c     = fix_quot(s3_a_decay, s3_q_decay);

  always_comb begin
    steps_c.rise_ord  = cap_step(q_rise_c, max_step);
    steps_c.decay_ord = cap_step(q_decay_c, max_step);
    steps_c.rise_ho   = cap_step(q_rise_c, HANDOFF_CAP);
    steps_c.decay_ho  = cap_step(q_decay_c, HANDOFF_CAP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= req_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1 <= req_data;
    end
    if (ld2) begin
      s2_ctl        <= ctl_c;
      s2_prod_rise  <= prod_rise_c;
      s2_prod_decay <= prod_decay_c;
    end
    if (ld3) begin
      s3_ctl     <= s2_ctl;
      s3_a_rise  <= s2_prod_rise[37:DIV_SHIFT];
      s3_a_decay <= s2_prod_decay[37:DIV_SHIFT];
      s3_q_rise  <= recip_rise_c[63:RECIP_SHIFT];
      s3_q_decay <= recip_decay_c[63:RECIP_SHIFT];
    end
    if (ld4) begin
      s4_ctl   <= s3_ctl;
      s4_steps <= steps_c;
    end
  end

  // Held-state update.
  always_comb begin
    changed = primed && (last_id != s4_ctl.object_id);
    handoff = primed && (last_id != '0) && (last_id == s4_ctl.object_id) &&
              (last_mode == MODE_ACQUIRE) && (s4_ctl.mode_code == MODE_FOLLOW);
    base_x = changed ? 16'sd0 : level_x;
    base_y = changed ? 16'sd0 : level_y;
    rqx = (s4_ctl.lifecycle == LIFE_CONT) ? no_rise(s4_ctl.rx, base_x) : s4_ctl.rx;
    rqy = (s4_ctl.lifecycle == LIFE_CONT) ? no_rise(s4_ctl.ry, base_y) : s4_ctl.ry;
    if (handoff) begin
      level_x_next = handoff_slew(level_x, s4_ctl.rx, s4_steps.rise_ho, s4_steps.decay_ho);
      level_y_next = handoff_slew(level_y, s4_ctl.ry, s4_steps.rise_ho, s4_steps.decay_ho);
    end else begin
      level_x_next = slew_axis(base_x, rqx, s4_steps.rise_ord, s4_steps.decay_ord);
      level_y_next = slew_axis(base_y, rqy, s4_steps.rise_ord, s4_steps.decay_ord);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      level_x   <= '0;
      level_y   <= '0;
      last_id   <= '0;
      last_mode <= MODE_MANUAL;
      primed    <= 1'b0;
    end else if (ld_out) begin
      res_valid <= v4;
      if (v4) begin
        level_x   <= level_x_next;
        level_y   <= level_y_next;
        last_id   <= s4_ctl.object_id;
        last_mode <= s4_ctl.mode_code;
        primed    <= 1'b1;
      end
    end
  end

  assign res_data.out_x = level_x;
  assign res_data.out_y = level_y;

  `ASSERT_CLK(a_reset_empty, rst |=> !res_valid && !v1 && !v4 && !primed, "reset left work")
  `ASSERT_CLKD(a_take_fills, req_valid && !req_stall |=> v1, "taken transfer not registered")
  `ASSERT_CLKD(a_state_hold, !(v4 && ld_out) |=> $stable({level_x, level_y}), "held pair moved")
  `ASSERT_CLKD(a_primed_res, res_valid |-> primed, "result shown before any update")

endmodule

`default_nettype wire
